/* sv/ctfm_pkg.sv */
// Shared constants, register indexes, mode codes and stage control type
// for the cron time field matcher. No dependencies.
`timescale 1ns / 1ps

package ctfm_pkg;

    // Schedule geometry
    localparam int SEQ_MAX_DEF = 8;
    localparam int NUM_FIELDS  = 5;
    localparam int VAL_W       = 6;
    localparam int CNT_W       = 4;
    localparam int CNT_LSB     = 48;
    localparam int OPS_W       = 52;
    localparam int MODE_W      = 3;
    localparam int MODES_W     = NUM_FIELDS * MODE_W;

    // Stream and config port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = OPS_W;

    // Input field widths, minute first
    localparam int MINUTE_W  = 6;
    localparam int HOUR_W    = 5;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int WEEKDAY_W = 3;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_MODES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_OPS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_OPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_OPS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MONTH_OPS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_OPS = 3'd5;

    // Field mode codes; 5..7 never match
    localparam logic [MODE_W-1:0] MODE_EXACT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WILD     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RANGE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST     = 3'd4;

    // Per-stage advance strobes handed to the lanes
    typedef struct packed {
        logic en_a;
        logic en_b;
    } stage_en_t;

endpackage

/* sv/ctfm_lane.sv */
// One field lane: mode decode, exact/range/list compares and a two-stage
// restoring remainder unit for periodic mode. Depends on ctfm_pkg.
`timescale 1ns / 1ps

module ctfm_lane #(
    parameter int SEQ_MAX = ctfm_pkg::SEQ_MAX_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ctfm_pkg::stage_en_t                    stage_en,
    input  logic [ctfm_pkg::MODE_W-1:0]            mode,
    input  logic [((SEQ_MAX < 2) ? 2 : SEQ_MAX)*ctfm_pkg::VAL_W-1:0] slots,
    input  logic [ctfm_pkg::CNT_W-1:0]             count,
    input  logic [ctfm_pkg::VAL_W-1:0]             t,
    output logic                                   hit
);

    localparam int VW = ctfm_pkg::VAL_W;
    localparam int HALF = VW / 2;

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [VW-1:0] rem_step(
        input logic [VW-1:0] rem,
        input logic          dbit,
        input logic [VW-1:0] d
    );
        logic [VW:0] wide;
        begin
            wide = {rem, dbit};
            if (wide >= {1'b0, d})
            begin
                wide = wide - {1'b0, d};
            end
            rem_step = wide[VW-1:0];
        end
    endfunction

    logic [VW-1:0]              v0;
    logic [VW-1:0]              v1;
    logic [ctfm_pkg::CNT_W-1:0] cnt_sat;
    logic                       list_hit;
    logic                       other_hit;
    logic                       periodic_ok;
    logic [VW-1:0]              rem_a;
    logic [VW-1:0]              rem_b;

    // Stage A registers
    logic            other_reg,    other_next;
    logic            periodic_reg, periodic_next;
    logic [VW-1:0]   rem_reg,      rem_next;
    logic [HALF-1:0] low_reg,      low_next;
    // Stage B register
    logic            hit_reg,      hit_next;

    assign v0 = slots[VW-1:0];
    assign v1 = slots[2*VW-1:VW];

    always_comb
    begin
        cnt_sat = (count > ctfm_pkg::CNT_W'(SEQ_MAX)) ? ctfm_pkg::CNT_W'(SEQ_MAX) : count;
        list_hit = 1'b0;
        for (int k = 0; k < SEQ_MAX; k++)
        begin
            if ((ctfm_pkg::CNT_W'(k) < cnt_sat) && (slots[k*VW +: VW] == t))
            begin
                list_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        periodic_ok = 1'b0;
        unique case (mode)
            ctfm_pkg::MODE_EXACT:    other_hit = (t == v0);
            ctfm_pkg::MODE_WILD:     other_hit = 1'b1;
            ctfm_pkg::MODE_PERIODIC:
            begin
                other_hit   = 1'b0;
                periodic_ok = (v0 != '0);
            end
            ctfm_pkg::MODE_RANGE:    other_hit = (v0 <= t) && (t <= v1);
            ctfm_pkg::MODE_LIST:     other_hit = list_hit;
            default:                 other_hit = 1'b0;
        endcase
    end

    // Upper dividend bits in stage A
    always_comb
    begin
        rem_a = '0;
        for (int i = VW - 1; i >= HALF; i--)
        begin
            rem_a = rem_step(rem_a, t[i], v0);
        end
    end

    assign other_next    = other_hit;
    assign periodic_next = periodic_ok;
    assign rem_next      = rem_a;
    assign low_next      = t[HALF-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en.en_a)
        begin
            other_reg    <= other_next;
            periodic_reg <= periodic_next;
            rem_reg      <= rem_next;
            low_reg      <= low_next;
        end
    end

    // Lower dividend bits in stage B; the user must keep the divisor static while busy, not enforced here
    always_comb
    begin
        rem_b = rem_reg;
        for (int i = HALF - 1; i >= 0; i--)
        begin
            rem_b = rem_step(rem_b, low_reg[i], v0);
        end
        hit_next = periodic_reg ? (rem_b == '0) : other_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (stage_en.en_b)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

/* sv/ctfm_merge.sv */
// Merge stage: ANDs the lane hits and holds the result beat in the
// output register. Depends on ctfm_pkg.
`timescale 1ns / 1ps

module ctfm_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [ctfm_pkg::NUM_FIELDS-1:0]     lane_hits,
    output logic                                m_tvalid,
    output logic [ctfm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic                                 valid_reg, valid_next;
    logic [ctfm_pkg::OUT_TDATA_W-1:0]     data_reg,  data_next;

    assign valid_next = in_valid;

    always_comb
    begin
        data_next = '0;
        data_next[0] = &lane_hits;
        data_next[ctfm_pkg::NUM_FIELDS:1] = lane_hits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* sv/cron_time_field_match.sv */
// Top level of the cron time field matcher: config registers, input
// register, five field lanes and the merge stage. Depends on ctfm_pkg,
// ctfm_lane and ctfm_merge.
`timescale 1ns / 1ps

//  channel   dir  handshake           payload (lowest bit first)
//  -------   ---  ------------------  --------------------------------------------
//  s_*       in   s_tvalid/s_tready   minute, hour, day_of_month, month_number,
//                                     weekday, pad
//  m_*       out  m_tvalid/m_tready   schedule_hit, field_hits, pad
//  cfg_*     in   cfg_wr_en           cfg_index selects register, cfg_data value
//
//  A beat passes through the input register, lane stage A, lane stage B and
//  the output register. One beat per cycle sustained while m_tready is high.
//  The periodic remainder is split over lane stages A and B, 3 bits each.
//  Each stage moves when the one after it is empty or moving, so bubbles
//  close up while m_tready is low and s_tready only drops once all fill.
//  Reset clears all valid bits and all config registers to zero.

module cron_time_field_match #(
    parameter int SEQ_MAX = ctfm_pkg::SEQ_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Config write port
    input  logic                                cfg_wr_en,
    input  logic [ctfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Time beats in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // minute[5:0], hour[10:6], day_of_month[15:11], month_number[19:16],
    // weekday[22:20], zero[23]
    input  logic [ctfm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Match beats out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // schedule_hit[0], field_hits[5:1], zero[7:6]
    output logic [ctfm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int NF     = ctfm_pkg::NUM_FIELDS;
    localparam int VW     = ctfm_pkg::VAL_W;
    localparam int CW     = ctfm_pkg::CNT_W;
    localparam int MW     = ctfm_pkg::MODE_W;
    // Range mode needs slot 1 even with a one-entry list
    localparam int SLOTS  = (SEQ_MAX < 2) ? 2 : SEQ_MAX;
    localparam int SLOT_W = SLOTS * VW;

    // Input field offsets in s_tdata
    localparam int HOUR_LSB    = ctfm_pkg::MINUTE_W;
    localparam int DAY_LSB     = HOUR_LSB + ctfm_pkg::HOUR_W;
    localparam int MONTH_LSB   = DAY_LSB + ctfm_pkg::DAY_W;
    localparam int WEEKDAY_LSB = MONTH_LSB + ctfm_pkg::MONTH_W;

    // ---------------- config registers ----------------
    logic [ctfm_pkg::MODES_W-1:0] modes_reg, modes_next;
    logic [SLOT_W-1:0]            slots_reg [NF];
    logic [SLOT_W-1:0]            slots_next [NF];
    logic [CW-1:0]                count_reg [NF];
    logic [CW-1:0]                count_next [NF];

    always_comb
    begin
        modes_next = modes_reg;
        for (int f = 0; f < NF; f++)
        begin
            slots_next[f] = slots_reg[f];
            count_next[f] = count_reg[f];
        end
        if (cfg_wr_en)
        begin
            unique case (cfg_index) inside
                ctfm_pkg::REG_FIELD_MODES:
                    modes_next = cfg_data[ctfm_pkg::MODES_W-1:0];
                ctfm_pkg::REG_MINUTE_OPS,
                ctfm_pkg::REG_HOUR_OPS,
                ctfm_pkg::REG_DAY_OPS,
                ctfm_pkg::REG_MONTH_OPS,
                ctfm_pkg::REG_WEEKDAY_OPS:
                begin
                    // operand registers follow the modes register in order
                    for (int f = 0; f < NF; f++)
                    begin
                        if (cfg_index == ctfm_pkg::CFG_IDX_W'(f + 1))
                        begin
                            slots_next[f] = cfg_data[SLOT_W-1:0];
                            count_next[f] = cfg_data[ctfm_pkg::CNT_LSB +: CW];
                        end
                    end
                end
                default:
                begin
                    // unused indexes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= '0;
            for (int f = 0; f < NF; f++)
            begin
                slots_reg[f] <= '0;
                count_reg[f] <= '0;
            end
        end
        else
        begin
            modes_reg <= modes_next;
            for (int f = 0; f < NF; f++)
            begin
                slots_reg[f] <= slots_next[f];
                count_reg[f] <= count_next[f];
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic                in_valid_reg, in_valid_next;
    logic                a_valid_reg,  a_valid_next;
    logic                b_valid_reg,  b_valid_next;
    logic                en_in;
    logic                en_a;
    logic                en_b;
    logic                en_out;
    ctfm_pkg::stage_en_t stage_en;

    assign en_out   = !m_tvalid || m_tready;
    assign en_b     = !b_valid_reg || en_out;
    assign en_a     = !a_valid_reg || en_b;
    assign en_in    = !in_valid_reg || en_a;
    assign s_tready = en_in;

    always_comb
    begin
        stage_en.en_a = en_a;
        stage_en.en_b = en_b;
    end

    assign in_valid_next = s_tvalid;
    assign a_valid_next  = in_valid_reg;
    assign b_valid_next  = a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                in_valid_reg <= in_valid_next;
            end
            if (en_a)
            begin
                a_valid_reg <= a_valid_next;
            end
            if (en_b)
            begin
                b_valid_reg <= b_valid_next;
            end
        end
    end

    // ---------------- input register ----------------
    // Every field widened to the slot width; compares use the full field width.
    logic [VW-1:0] t_reg  [NF];
    logic [VW-1:0] t_next [NF];

    always_comb
    begin
        t_next[0] = VW'(s_tdata[HOUR_LSB-1:0]);
        t_next[1] = VW'(s_tdata[DAY_LSB-1:HOUR_LSB]);
        t_next[2] = VW'(s_tdata[MONTH_LSB-1:DAY_LSB]);
        t_next[3] = VW'(s_tdata[WEEKDAY_LSB-1:MONTH_LSB]);
        t_next[4] = VW'(s_tdata[WEEKDAY_LSB + ctfm_pkg::WEEKDAY_W - 1:WEEKDAY_LSB]);
    end

    always_ff @(posedge clk)
    begin
        if (en_in && s_tvalid)
        begin
            for (int f = 0; f < NF; f++)
            begin
                t_reg[f] <= t_next[f];
            end
        end
    end

    // ---------------- field lanes ----------------
    logic [NF-1:0] lane_hits;

    for (genvar f = 0; f < NF; f++)
    begin : g_lane
        ctfm_lane #(
            .SEQ_MAX (SEQ_MAX)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage_en (stage_en),
            .mode     (modes_reg[f*MW +: MW]),
            .slots    (slots_reg[f]),
            .count    (count_reg[f]),
            .t        (t_reg[f]),
            .hit      (lane_hits[f])
        );
    end

    // ---------------- merge and output register ----------------
    ctfm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_out),
        .in_valid  (b_valid_reg),
        .lane_hits (lane_hits),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
